>>> rtl/fut_pkg.sv
// fut_pkg: types, character codes and helper functions for the frequency text parser
// no dependencies; imported by every module of the block and by its checker

package fut_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int FREQ_W    = 64;
    localparam int FRAC_W    = 30;
    localparam int CNT_W     = 4;
    localparam int WEIGHT_W  = 27;
    localparam int MUL_W     = FREQ_W + 10;

    // exact floor(x / 1000) for x below 2**32: x * ceil(2**38 / 1000) >> 38
    localparam int                 MAGIC_W    = 29;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC  = 29'd274877907;
    localparam int                 DIV_SHIFT  = 38;
    localparam int                 QPROD_W    = FRAC_W + MAGIC_W;

    localparam logic [CNT_W-1:0] MAX_FRAC_DIGITS = 4'd9;

    // character codes
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_G     = 8'h67;
    localparam logic [BYTE_W-1:0] CHAR_H     = 8'h68;
    localparam logic [BYTE_W-1:0] CHAR_K     = 8'h6B;
    localparam logic [BYTE_W-1:0] CHAR_M     = 8'h6D;
    localparam logic [BYTE_W-1:0] CHAR_Z     = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_GAP   = 8'h20;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_INT,
        PH_FRAC,
        PH_GAP,
        PH_UNIT,
        PH_TRAIL,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        UNIT_HZ  = 2'd0,
        UNIT_KHZ = 2'd1,
        UNIT_MHZ = 2'd2,
        UNIT_GHZ = 2'd3
    } unit_t;

    // one finished text on its way through the scaling stages
    typedef struct packed {
        logic              ok;
        logic              ovf;
        unit_t             unit;
        logic [1:0]        mul_left;
        logic [FREQ_W-1:0] int_val;
        logic [FRAC_W-1:0] frac;
    } work_t;

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

    function automatic logic is_num(input logic [BYTE_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_end_mark(input logic [BYTE_W-1:0] c);
        return (c == CHAR_SLASH) || (c == CHAR_NUL);
    endfunction

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic [BYTE_W-1:0] down_case(input logic [BYTE_W-1:0] c);
        return (c inside {[8'h41:8'h5A]}) ? (c + CASE_GAP) : c;
    endfunction

    // weight of the next fraction digit, so the fraction is held as nine digits
    function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [CNT_W-1:0] cnt);
        logic [WEIGHT_W-1:0] w;
        case (cnt)
            4'd0:    w = 27'd100000000;
            4'd1:    w = 27'd10000000;
            4'd2:    w = 27'd1000000;
            4'd3:    w = 27'd100000;
            4'd4:    w = 27'd10000;
            4'd5:    w = 27'd1000;
            4'd6:    w = 27'd100;
            4'd7:    w = 27'd10;
            4'd8:    w = 27'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/fut_parser.sv
// fut_parser: per-byte text state machine with integer and fraction accumulators
// depends on fut_pkg; hands each finished text to the scaling stages as a work_t

module fut_parser
    import fut_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              last_byte,
    output logic              work_valid,
    input  logic              work_ready,
    output work_t             work
);

    phase_t              phase_reg,   phase_next;
    logic [FREQ_W-1:0]   int_reg,     int_next;
    logic                ovf_reg,     ovf_next;
    logic [FRAC_W-1:0]   frac_reg,    frac_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    unit_t               unit_reg,    unit_next;
    logic                want_z_reg,  want_z_next;
    logic                work_valid_reg;
    work_t               work_reg;

    logic [BYTE_W-1:0]   lc;
    logic [3:0]          digit;
    logic                start_hit;
    unit_t               start_code;
    phase_t              after_phase;
    logic [FREQ_W+3:0]   int_step;
    logic                accept;
    logic                ok;

    assign lc     = down_case(text_byte);
    assign digit  = text_byte[3:0];
    assign accept = byte_valid && byte_ready;

    assign byte_ready = !work_valid_reg || work_ready;
    assign work_valid = work_valid_reg;
    assign work       = work_reg;

    // first letter of a unit word
    always_comb
    begin
        start_hit  = 1'b1;
        case (lc)
            CHAR_G:  start_code = UNIT_GHZ;
            CHAR_M:  start_code = UNIT_MHZ;
            CHAR_K:  start_code = UNIT_KHZ;
            CHAR_H:  start_code = UNIT_HZ;
            default:
            begin
                start_code = UNIT_HZ;
                start_hit  = 1'b0;
            end
        endcase
    end

    // byte after a number or blanks
    always_comb
    begin
        if (is_blank(text_byte))
            after_phase = PH_GAP;
        else if (is_end_mark(text_byte))
            after_phase = PH_DONE;
        else if (is_letter(text_byte) && start_hit)
            after_phase = PH_UNIT;
        else
            after_phase = PH_ERR;
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_LEAD:
            begin
                if (is_blank(text_byte))
                    phase_next = PH_LEAD;
                else if (is_num(text_byte))
                    phase_next = PH_INT;
                else
                    phase_next = PH_ERR;
            end
            PH_INT:
            begin
                if (is_num(text_byte))
                    phase_next = PH_INT;
                else if (text_byte == CHAR_DOT)
                    phase_next = PH_FRAC;
                else
                    phase_next = after_phase;
            end
            PH_FRAC:
            begin
                if (is_num(text_byte))
                    phase_next = PH_FRAC;
                else
                    phase_next = after_phase;
            end
            PH_GAP:
                phase_next = after_phase;
            PH_UNIT:
            begin
                if (lc != (want_z_reg ? CHAR_Z : CHAR_H))
                    phase_next = PH_ERR;
                else if (want_z_reg)
                    phase_next = PH_TRAIL;
                else
                    phase_next = PH_UNIT;
            end
            PH_TRAIL:
            begin
                if (is_blank(text_byte))
                    phase_next = PH_TRAIL;
                else if (is_end_mark(text_byte))
                    phase_next = PH_DONE;
                else
                    phase_next = PH_ERR;
            end
            PH_DONE:
                phase_next = PH_DONE;
            default:
                phase_next = PH_ERR;
        endcase
    end

    // x * 10 + d, with room to see a carry past 64 bits
    assign int_step = ({4'b0, int_reg} << 3) + ({4'b0, int_reg} << 1)
                    + {{FREQ_W{1'b0}}, digit};

    // accumulator updates
    always_comb
    begin
        int_next    = int_reg;
        ovf_next    = ovf_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        unit_next   = unit_reg;
        want_z_next = want_z_reg;

        if (is_num(text_byte) && (phase_reg == PH_LEAD || phase_reg == PH_INT))
        begin
            if (ovf_reg || (int_step[FREQ_W+3:FREQ_W] != 4'd0))
            begin
                int_next = '1;
                ovf_next = 1'b1;
            end
            else
                int_next = int_step[FREQ_W-1:0];
        end

        // digits past the ninth are dropped; weight times digit needs the full 30 bits
        if (is_num(text_byte) && phase_reg == PH_FRAC && cnt_reg < MAX_FRAC_DIGITS)
        begin
            frac_next = frac_reg
                      + ({{(FRAC_W-WEIGHT_W){1'b0}}, frac_weight(cnt_reg)}
                         * {{(FRAC_W-4){1'b0}}, digit});
            cnt_next  = cnt_reg + 4'd1;
        end

        if (phase_next == PH_UNIT && phase_reg != PH_UNIT)
        begin
            unit_next   = start_code;
            want_z_next = (lc == CHAR_H);
        end
        else if (phase_reg == PH_UNIT && phase_next == PH_UNIT)
            want_z_next = 1'b1;
    end

    assign ok = phase_next inside {PH_INT, PH_FRAC, PH_GAP, PH_TRAIL, PH_DONE};

    // parse state, back to its start after every last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEAD;
            int_reg    <= '0;
            ovf_reg    <= 1'b0;
            frac_reg   <= '0;
            cnt_reg    <= '0;
            unit_reg   <= UNIT_HZ;
            want_z_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg  <= PH_LEAD;
                int_reg    <= '0;
                ovf_reg    <= 1'b0;
                frac_reg   <= '0;
                cnt_reg    <= '0;
                unit_reg   <= UNIT_HZ;
                want_z_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                int_reg    <= int_next;
                ovf_reg    <= ovf_next;
                frac_reg   <= frac_next;
                cnt_reg    <= cnt_next;
                unit_reg   <= unit_next;
                want_z_reg <= want_z_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            work_valid_reg <= 1'b0;
        else if (byte_ready)
            work_valid_reg <= accept && last_byte;
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            work_reg.ok       <= ok;
            work_reg.ovf      <= ovf_next;
            work_reg.unit     <= unit_next;
            work_reg.mul_left <= unit_next;
            work_reg.int_val  <= int_next;
            work_reg.frac     <= frac_next;
        end
    end

endmodule

>>> rtl/fut_scale_stage.sv
// fut_scale_stage: one registered step that multiplies the integer by 1000 or
// divides the nine-digit fraction by 1000; depends on fut_pkg

module fut_scale_stage
    import fut_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_work,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_work
);

    logic               valid_reg;
    work_t              work_reg;
    work_t              work_next;
    logic [MUL_W-1:0]   prod;
    logic [QPROD_W-1:0] qprod;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    // 1000 = 1024 - 16 - 8
    assign prod  = ({10'b0, in_work.int_val} << 10) - ({10'b0, in_work.int_val} << 4)
                 - ({10'b0, in_work.int_val} << 3);
    assign qprod = {{MAGIC_W{1'b0}}, in_work.frac} * {{FRAC_W{1'b0}}, DIV_MAGIC};

    // unit code sets how many steps multiply; the rest divide the fraction
    always_comb
    begin
        work_next = in_work;
        if (in_work.mul_left != 2'd0)
        begin
            work_next.int_val  = prod[FREQ_W-1:0];
            work_next.ovf      = in_work.ovf || (prod[MUL_W-1:FREQ_W] != '0);
            work_next.mul_left = in_work.mul_left - 2'd1;
        end
        else
            work_next.frac = FRAC_W'(qprod[QPROD_W-1:DIV_SHIFT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            work_reg <= work_next;
    end

endmodule

>>> rtl/frequency_unit_text_parser.sv
// frequency_unit_text_parser: top level of the frequency text parser
// depends on fut_pkg, fut_parser and fut_scale_stage

// Takes frequency text one byte per transfer (tlast on the final byte) and
// gives one result per text: status, frequency in hertz and the unit seen.
// Accepted form: optional blanks, decimal digits, an optional '.' and
// fraction, optional blanks, an optional unit (hz, khz, mhz, ghz in any
// case) and trailing blanks; a '/' or NUL ends the text early and bytes
// after it are ignored up to tlast. The value is held as an exact decimal
// (integer part plus nine fraction digits), so the result is the true value
// truncated toward zero. Malformed text gives status 1 with zero frequency
// and unit; a value past 64 bits gives status 2 with all ones.
// One byte is taken every clock while the parser's work register is free or
// being emptied, also while a result waits at the output. A result passes
// from the parser's work register, loaded on the transfer of the last byte,
// through three scaling stages (each one multiply by 1000 as shift-and-add,
// or one divide by 1000 as a reciprocal multiply) to the output register
// that adds integer and fraction parts. A stalled output backs up through
// the stages only once they are all full.

module frequency_unit_text_parser
    import fut_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] text_byte
    input  logic              s_axis_tlast,   // last_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [FREQ_W-1:0] m_axis_tdata,   // [63:0] frequency in hertz
    output logic [3:0]        m_axis_tuser    // [1:0] status, [3:2] unit_code
);

    localparam int NUM_STAGES = 3;

    // chain of work items: index 0 from the parser, last into the output register
    logic  chain_valid [NUM_STAGES+1];
    logic  chain_ready [NUM_STAGES+1];
    work_t chain_work  [NUM_STAGES+1];

    logic              out_valid_reg;
    logic [FREQ_W-1:0] out_freq_reg;
    status_t           out_status_reg;
    unit_t             out_unit_reg;

    logic              out_load;
    work_t             fin;
    logic [FREQ_W:0]   sum;
    logic              fin_ovf;
    status_t           fin_status;
    logic [FREQ_W-1:0] fin_freq;
    unit_t             fin_unit;

    fut_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .text_byte  (s_axis_tdata),
        .last_byte  (s_axis_tlast),
        .work_valid (chain_valid[0]),
        .work_ready (chain_ready[0]),
        .work       (chain_work[0])
    );

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_stage
        fut_scale_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_work   (chain_work[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_work  (chain_work[i+1])
        );
    end

    // output register: frees as the current result is taken
    assign out_load                = !out_valid_reg || m_axis_tready;
    assign chain_ready[NUM_STAGES] = out_load;
    assign fin                     = chain_work[NUM_STAGES];

    // integer times unit plus scaled fraction, carry out means overflow
    assign sum     = {1'b0, fin.int_val} + {{(FREQ_W-FRAC_W+1){1'b0}}, fin.frac};
    assign fin_ovf = fin.ovf || sum[FREQ_W];

    always_comb
    begin
        if (!fin.ok)
        begin
            fin_status = STATUS_MALFORMED;
            fin_freq   = '0;
            fin_unit   = UNIT_HZ;
        end
        else if (fin_ovf)
        begin
            fin_status = STATUS_OVERFLOW;
            fin_freq   = '1;
            fin_unit   = fin.unit;
        end
        else
        begin
            fin_status = STATUS_OK;
            fin_freq   = sum[FREQ_W-1:0];
            fin_unit   = fin.unit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= chain_valid[NUM_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (out_load && chain_valid[NUM_STAGES])
        begin
            out_freq_reg   <= fin_freq;
            out_status_reg <= fin_status;
            out_unit_reg   <= fin_unit;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_freq_reg;
    assign m_axis_tuser  = {out_unit_reg, out_status_reg};

endmodule

>>> rtl/fut_checker.sv
// fut_checker: port-level assertions for frequency_unit_text_parser
// depends on fut_pkg; attached to the top level by the bind at the end

module fut_checker
    import fut_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [FREQ_W-1:0] m_axis_tdata,
    input logic [3:0]        m_axis_tuser
);

    // a stalled result transfer keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // status code three is never produced
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("undefined status code");

    // malformed text carries zero frequency and zero unit
    a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == STATUS_MALFORMED |->
            m_axis_tdata == '0 && m_axis_tuser[3:2] == UNIT_HZ)
        else $error("malformed result not cleared");

    // overflow saturates the frequency
    a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == STATUS_OVERFLOW |-> m_axis_tdata == '1)
        else $error("overflow result not saturated");

endmodule

bind frequency_unit_text_parser fut_checker u_fut_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/frequency_unit_text_parser_tb.sv
// frequency_unit_text_parser_tb: self-checking bench for the frequency text parser
// feeds whole texts a byte per transfer and checks every result against a local model or a given reading
// depends on fut_pkg and frequency_unit_text_parser

module frequency_unit_text_parser_tb;
    import fut_pkg::*;

    // plain character codes not held in the package
    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5A;
    localparam logic [BYTE_W-1:0] LOWER_A    = 8'h61;
    localparam logic [BYTE_W-1:0] HIGH_BYTE  = 8'hFF;
    localparam logic [FREQ_W-1:0] FREQ_SAT   = '1;

    // stand-ins used in the directed texts for bytes a string cannot carry
    localparam logic [BYTE_W-1:0] NUL_STAND_IN  = "~";
    localparam logic [BYTE_W-1:0] HIGH_STAND_IN = "^";

    localparam int RANDOM_BYTES   = 210;
    localparam int PRESSURE_TEXTS = 30;
    localparam int HOLD_OFF       = 150;

    typedef struct packed {
        status_t           status;
        logic [FREQ_W-1:0] hz;
        unit_t             unit;
    } reading_t;

    typedef struct {
        string    text;
        bit       given;
        reading_t want;
    } text_row_t;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [FREQ_W-1:0] m_axis_tdata;
    logic [3:0]        m_axis_tuser;

    // readings owed by the block, oldest first
    reading_t  readings_due[$];
    text_row_t directed_rows[$];

    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int sink_hold_left = 0;
    int mismatch_count = 0;

    // local copy of the parser state
    phase_t            text_phase = PH_LEAD;
    logic [FREQ_W-1:0] int_value  = '0;
    logic [FRAC_W-1:0] frac_value = '0;
    logic [CNT_W-1:0]  frac_count = '0;
    unit_t             unit_seen  = UNIT_HZ;
    logic [1:0]        unit_pos   = '0;
    logic              int_ovf    = 1'b0;

    frequency_unit_text_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #4800000;
        $display("frequency_unit_text_parser verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // text model
    // ------------------------------------------------------------------

    function automatic bit is_gap_char(input logic [BYTE_W-1:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

    function automatic bit is_digit_char(input logic [BYTE_W-1:0] c);
        return (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
    endfunction

    function automatic bit is_stop_char(input logic [BYTE_W-1:0] c);
        return (c == CHAR_SLASH) || (c == CHAR_NUL);
    endfunction

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        return ((c >= UPPER_A) && (c <= UPPER_Z)) ? c + CASE_GAP : c;
    endfunction

    function automatic bit is_alpha_char(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] l;
        l = fold_case(c);
        return (l >= LOWER_A) && (l <= CHAR_Z);
    endfunction

    function automatic logic [FREQ_W-1:0] unit_factor(input unit_t u);
        case (u)
            UNIT_KHZ: return 64'd1000;
            UNIT_MHZ: return 64'd1000000;
            UNIT_GHZ: return 64'd1000000000;
            default:  return 64'd1;
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] ten_pow(input logic [CNT_W-1:0] n);
        logic [FREQ_W-1:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic void clear_parse();
        text_phase = PH_LEAD;
        int_value  = '0;
        frac_value = '0;
        frac_count = '0;
        unit_seen  = UNIT_HZ;
        unit_pos   = '0;
        int_ovf    = 1'b0;
    endfunction

    // integer digit with saturation; once saturated it stays there
    function automatic void push_int_digit(input logic [BYTE_W-1:0] c);
        logic [FREQ_W-1:0] d;
        d = 64'(c - DIGIT_ZERO);
        if (int_ovf)
            int_value = FREQ_SAT;
        else if (int_value > (FREQ_SAT - d) / 64'd10)
        begin
            int_ovf   = 1'b1;
            int_value = FREQ_SAT;
        end
        else
            int_value = int_value * 64'd10 + d;
    endfunction

    // byte after a number or a gap: blank, end mark or first unit letter
    function automatic phase_t after_number(input logic [BYTE_W-1:0] c);
        if (is_gap_char(c))
            return PH_GAP;
        if (is_stop_char(c))
            return PH_DONE;
        if (!is_alpha_char(c))
            return PH_ERR;
        case (fold_case(c))
            CHAR_G:
            begin
                unit_seen = UNIT_GHZ;
                unit_pos  = 2'd1;
            end
            CHAR_M:
            begin
                unit_seen = UNIT_MHZ;
                unit_pos  = 2'd1;
            end
            CHAR_K:
            begin
                unit_seen = UNIT_KHZ;
                unit_pos  = 2'd1;
            end
            CHAR_H:
            begin
                unit_seen = UNIT_HZ;
                unit_pos  = 2'd2;
            end
            default: return PH_ERR;
        endcase
        return PH_UNIT;
    endfunction

    // one accepted byte; gives a reading when the byte closes the text
    function automatic bit parse_step(input logic [BYTE_W-1:0] c, input bit last,
                                      output reading_t rd);
        phase_t            ph;
        logic [BYTE_W-1:0] want;
        logic [FREQ_W-1:0] mult;
        logic [FREQ_W-1:0] fpart;
        logic [FREQ_W-1:0] total;
        logic              ovf;
        ph = text_phase;
        rd = '{STATUS_OK, '0, UNIT_HZ};
        case (text_phase)
            PH_LEAD:
                if (is_digit_char(c))
                begin
                    push_int_digit(c);
                    ph = PH_INT;
                end
                else if (!is_gap_char(c))
                    ph = PH_ERR;
            PH_INT:
                if (is_digit_char(c))
                    push_int_digit(c);
                else if (c == CHAR_DOT)
                    ph = PH_FRAC;
                else
                    ph = after_number(c);
            PH_FRAC:
                if (is_digit_char(c))
                begin
                    // digits past the ninth are dropped
                    if (frac_count < MAX_FRAC_DIGITS)
                    begin
                        frac_value = frac_value * 30'd10 + 30'(c - DIGIT_ZERO);
                        frac_count = frac_count + 4'd1;
                    end
                end
                else
                    ph = after_number(c);
            PH_GAP:
                ph = after_number(c);
            PH_UNIT:
            begin
                want = (unit_pos == 2'd1) ? CHAR_H : CHAR_Z;
                if (fold_case(c) != want)
                    ph = PH_ERR;
                else if (want == CHAR_Z)
                    ph = PH_TRAIL;
                else
                    unit_pos = 2'd2;
            end
            PH_TRAIL:
                if (is_stop_char(c))
                    ph = PH_DONE;
                else if (!is_gap_char(c))
                    ph = PH_ERR;
            PH_DONE: ;
            default:
                ph = PH_ERR;
        endcase
        text_phase = ph;

        if (!last)
            return 1'b0;

        if (!(ph inside {PH_INT, PH_FRAC, PH_GAP, PH_TRAIL, PH_DONE}))
            rd.status = STATUS_MALFORMED;
        else
        begin
            mult  = unit_factor(unit_seen);
            fpart = (64'(frac_value) * mult) / ten_pow(frac_count);
            ovf   = int_ovf;
            total = '0;
            if (!ovf && (int_value > FREQ_SAT / mult))
                ovf = 1'b1;
            if (!ovf)
            begin
                total = int_value * mult;
                if (total > FREQ_SAT - fpart)
                    ovf = 1'b1;
                else
                    total = total + fpart;
            end
            rd.unit   = unit_seen;
            rd.status = ovf ? STATUS_OVERFLOW : STATUS_OK;
            rd.hz     = ovf ? FREQ_SAT : total;
        end
        clear_parse();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic add_row(input string text, input bit given = 1'b0,
                           input status_t st = STATUS_OK,
                           input logic [FREQ_W-1:0] hz = '0, input unit_t un = UNIT_HZ);
        text_row_t row;
        row.text  = text;
        row.given = given;
        row.want  = '{st, hz, un};
        directed_rows.push_back(row);
    endtask

    // offers a whole text, tlast on its final byte; the model steps on every transfer
    task automatic send_text(input logic [BYTE_W-1:0] txt[$], input bit given,
                             input reading_t want);
        reading_t got;
        bit       last;
        for (int i = 0; i < txt.size(); i++)
        begin
            last = (i == txt.size() - 1);
            while ($urandom_range(99) < src_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= txt[i];
            s_axis_tlast  <= last;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            if (parse_step(txt[i], last, got))
                readings_due.push_back(given ? want : got);
        end
    endtask

    // sender stands back until every owed reading has come out
    task automatic drain_readings();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (readings_due.size() != 0);
    endtask

    function automatic logic [BYTE_W-1:0] any_gap();
        return $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    function automatic logic [BYTE_W-1:0] any_digit();
        return DIGIT_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [BYTE_W-1:0] any_case(input logic [BYTE_W-1:0] l);
        return $urandom_range(1) ? l - CASE_GAP : l;
    endfunction

    // mostly well-formed texts with random content, some noise and some broken ones;
    // kept counts the bytes the block actually parses
    function automatic void random_text(output logic [BYTE_W-1:0] txt[$], output int kept);
        string near_max;
        int    kind;
        int    r;
        int    u;
        int    pos;
        near_max = "1844674407370955";
        txt.delete();
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 6))
                txt.push_back(8'($urandom_range(255)));
            kept = txt.size();
            return;
        end

        repeat ($urandom_range(2))
            txt.push_back(any_gap());

        // integer part: short, long, or straddling the 64-bit limit
        r = $urandom_range(99);
        if (r < 12)
        begin
            foreach (near_max[k])
                txt.push_back(near_max[k]);
            repeat ($urandom_range(4, 5))
                txt.push_back(any_digit());
        end
        else if (r < 35)
            repeat ($urandom_range(7, 19))
                txt.push_back(any_digit());
        else
            repeat ($urandom_range(1, 6))
                txt.push_back(any_digit());

        if ($urandom_range(1))
        begin
            txt.push_back(CHAR_DOT);
            repeat ($urandom_range(12))
                txt.push_back(any_digit());
        end

        repeat ($urandom_range(2))
            txt.push_back(any_gap());

        u = $urandom_range(4);
        if (u != 0)
        begin
            case (u)
                2: txt.push_back(any_case(CHAR_K));
                3: txt.push_back(any_case(CHAR_M));
                4: txt.push_back(any_case(CHAR_G));
                default: ;
            endcase
            txt.push_back(any_case(CHAR_H));
            txt.push_back(any_case(CHAR_Z));
            repeat ($urandom_range(2))
                txt.push_back(any_gap());
        end
        kept = txt.size();

        // early end mark followed by bytes the block should skip
        if ($urandom_range(4) == 0)
        begin
            txt.push_back($urandom_range(1) ? CHAR_SLASH : CHAR_NUL);
            repeat ($urandom_range(3))
                txt.push_back(8'($urandom_range(255)));
        end

        if (kind < 25)
        begin
            if ($urandom_range(1))
            begin
                pos = $urandom_range(txt.size() - 1);
                txt[pos] = 8'($urandom_range(255));
            end
            else
                while (txt.size() > 1 && $urandom_range(1))
                    void'(txt.pop_back());
            if (kept > txt.size())
                kept = txt.size();
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: random back-pressure plus an optional long hold-off
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        reading_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (readings_due.size() == 0)
                flag_mismatch($sformatf("result with nothing owed: tdata %h tuser %h",
                                        m_axis_tdata, m_axis_tuser));
            else
            begin
                due = readings_due.pop_front();
                if (m_axis_tuser[1:0] !== due.status)
                    flag_mismatch($sformatf("status %0d, wanted %0d",
                                            m_axis_tuser[1:0], due.status));
                if (m_axis_tdata !== due.hz)
                    flag_mismatch($sformatf("frequency %0d, wanted %0d",
                                            m_axis_tdata, due.hz));
                if (m_axis_tuser[3:2] !== due.unit)
                    flag_mismatch($sformatf("unit %0d, wanted %0d",
                                            m_axis_tuser[3:2], due.unit));
            end
        end
        if (sink_hold_left > 0)
        begin
            sink_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [BYTE_W-1:0] txt[$];
        logic [BYTE_W-1:0] ch;
        reading_t          none;
        int                kept;
        int                sent;

        none = '{STATUS_OK, '0, UNIT_HZ};
        sent = 0;

        // directed texts; '~' stands for a NUL byte and '^' for 0xFF
        add_row("0", 1'b1, STATUS_OK, '0, UNIT_HZ);
        add_row("18446744073709551615", 1'b1, STATUS_OK, FREQ_SAT, UNIT_HZ);
        add_row("18446744073709551616", 1'b1, STATUS_OVERFLOW, FREQ_SAT, UNIT_HZ);
        add_row("184467440737095516150", 1'b1, STATUS_OVERFLOW, FREQ_SAT, UNIT_HZ);
        add_row(" \t ", 1'b1, STATUS_MALFORMED, '0, UNIT_HZ);
        add_row(".5", 1'b1, STATUS_MALFORMED, '0, UNIT_HZ);
        add_row("5 k", 1'b1, STATUS_MALFORMED, '0, UNIT_HZ);
        add_row("12^", 1'b1, STATUS_MALFORMED, '0, UNIT_HZ);
        add_row("~", 1'b1, STATUS_MALFORMED, '0, UNIT_HZ);
        add_row("42 Hz x", 1'b1, STATUS_MALFORMED, '0, UNIT_HZ);
        add_row("1 kz", 1'b1, STATUS_MALFORMED, '0, UNIT_HZ);
        add_row(" \t1.5 kHz  ");
        add_row("2.25MHz");
        add_row("3.1234567891234GHz");
        add_row("100 hz");
        add_row("10GHZ");
        add_row("18446744073709552 kHz");
        add_row("18446744073.709551615 GHz");
        add_row("18446744073.709551616GhZ");
        add_row("5~xyz^");
        add_row("4.Hz");
        add_row("8.");
        add_row("3 /  q");
        add_row("0.000000001 GHz");
        add_row("999999999.999999999 hz");

        src_idle_pct  = 37;
        sink_idle_pct = 53;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            txt.delete();
            foreach (directed_rows[i].text[k])
            begin
                ch = directed_rows[i].text[k];
                if (ch == NUL_STAND_IN)
                    ch = CHAR_NUL;
                else if (ch == HIGH_STAND_IN)
                    ch = HIGH_BYTE;
                txt.push_back(ch);
            end
            send_text(txt, directed_rows[i].given, directed_rows[i].want);
        end
        drain_readings();

        // random texts in three idling regimes
        for (int stage = 0; stage < 3; stage++)
        begin
            if (stage == 1)
            begin
                src_idle_pct  = 53;
                sink_idle_pct = 37;
            end
            else if (stage == 2)
            begin
                // long receiver hold-off while one-byte texts keep coming,
                // so the pipeline fills and the input has to stall
                src_idle_pct   = 0;
                sink_idle_pct  = 0;
                sink_hold_left = HOLD_OFF;
                repeat (PRESSURE_TEXTS)
                begin
                    txt.delete();
                    txt.push_back(any_digit());
                    send_text(txt, 1'b0, none);
                end
                drain_readings();
            end
            while (sent < (stage + 1) * RANDOM_BYTES / 3)
            begin
                random_text(txt, kept);
                send_text(txt, 1'b0, none);
                sent += kept;
            end
            drain_readings();
        end

        // let any stray late result show up before judging
        repeat (16)
            @(posedge clk);

        if (mismatch_count == 0 && readings_due.size() == 0)
            $display("frequency_unit_text_parser verification clean");
        else
            $display("frequency_unit_text_parser verification failed");
        $finish;
    end

endmodule

>>> frequency_unit_text_parser.f
rtl/fut_pkg.sv
rtl/fut_parser.sv
rtl/fut_scale_stage.sv
rtl/frequency_unit_text_parser.sv
rtl/fut_checker.sv
tb/frequency_unit_text_parser_tb.sv
